>>> rtl/core/smte_pkg.sv
// Package for the Sobel magnitude threshold edge block.
// Holds size limits, register reset values and register indexes.
// Used by the top level; no dependencies.
package smte_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int HEIGHT_LIMIT  = 2048;
	localparam int ROW_BITS      = $clog2(HEIGHT_LIMIT);

	localparam int CFG_BITS   = 12;
	localparam int PIXEL_BITS = 8;
	localparam int THR_BITS   = 8;

	localparam logic [CFG_BITS-1:0]   WIDTH_RESET     = 12'd640;
	localparam logic [CFG_BITS-1:0]   HEIGHT_RESET    = 12'd480;
	localparam logic [THR_BITS-1:0]   THRESHOLD_RESET = 8'd100;
	localparam logic [PIXEL_BITS-1:0] EDGE_VALUE      = 8'd255;
	localparam logic [PIXEL_BITS-1:0] FLAT_VALUE      = 8'd0;

	localparam int ADDR_BITS = 4;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH    = 2'd0;
	localparam reg_idx_t REG_IMAGE_HEIGHT   = 2'd1;
	localparam reg_idx_t REG_EDGE_THRESHOLD = 2'd2;

endpackage

>>> rtl/core/smte_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is enabled.
// No dependencies.
module smte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/sobel_magnitude_threshold_edge.sv
// Top level of the 3x3 Sobel edge detector with squared-magnitude threshold.
// Depends on smte_pkg and on smte_ram, which holds both line stores side by side.
//
//   channel   signals                          direction
//   pixel     pix_valid, pix_stall, pixel_in    in
//   result    res_valid, res_stall, pixel_out,  out
//             last_of_frame
//   config    APB: psel ... prdata              in/out
//
// One pixel is accepted per cycle while the pipeline is not frozen; on its way to the output register
// a pixel passes the line store read, window sums, squares and compare stages in that order.
// The whole pipeline freezes only while the output register holds a result that is stalled.
// Reset clears positions, valids and registers; line store contents are undefined after
// reset, and the first two rows of a frame only produce border results, so no clear is run.
module sobel_magnitude_threshold_edge #(
	parameter int MAX_WIDTH = smte_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic [smte_pkg::PIXEL_BITS-1:0]     pixel_in,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [smte_pkg::PIXEL_BITS-1:0]     pixel_out,
	output logic                                last_of_frame,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [smte_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > smte_pkg::CFG_BITS) ? CW + 1 : smte_pkg::CFG_BITS;
	localparam int RW = smte_pkg::ROW_BITS;
	localparam int PW = smte_pkg::PIXEL_BITS;
	localparam int HB = smte_pkg::CFG_BITS;

	typedef struct packed {
		logic emit;
		logic full;
		logic last;
	} flags_t;

	// Configuration registers.
	logic [HB-1:0]                     width_q;
	logic [HB-1:0]                     height_q;
	logic [smte_pkg::THR_BITS-1:0]     thr_q;
	logic [2*smte_pkg::THR_BITS-1:0]   thr_sq_q;
	logic                              cfg_wr;
	smte_pkg::reg_idx_t                cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= smte_pkg::WIDTH_RESET;
			height_q <= smte_pkg::HEIGHT_RESET;
			thr_q    <= smte_pkg::THRESHOLD_RESET;
			thr_sq_q <= '0;
		end else begin
			thr_sq_q <= thr_q * thr_q;
			if (cfg_wr) begin
				case (cfg_idx)
					smte_pkg::REG_IMAGE_WIDTH:    width_q  <= pwdata[HB-1:0];
					smte_pkg::REG_IMAGE_HEIGHT:   height_q <= pwdata[HB-1:0];
					smte_pkg::REG_EDGE_THRESHOLD: thr_q    <= pwdata[smte_pkg::THR_BITS-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			smte_pkg::REG_IMAGE_WIDTH:    prdata = {{(32-HB){1'b0}}, width_q};
			smte_pkg::REG_IMAGE_HEIGHT:   prdata = {{(32-HB){1'b0}}, height_q};
			smte_pkg::REG_EDGE_THRESHOLD: prdata = {{(32-smte_pkg::THR_BITS){1'b0}}, thr_q};
			default:                      prdata = '0;
		endcase
	end

	// Effective frame size.
	logic [EW-1:0] width_ext;
	logic [EW-1:0] w_eff;
	logic [HB-1:0] h_eff;

	assign width_ext = EW'(width_q);

	always_comb begin
		if (width_ext < EW'(3)) begin
			w_eff = EW'(3);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = width_ext;
		end
		if (height_q < HB'(3)) begin
			h_eff = HB'(3);
		end else if (height_q > HB'(smte_pkg::HEIGHT_LIMIT)) begin
			h_eff = HB'(smte_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = height_q;
		end
	end

	// Handshake and raster position.
	logic           adv;
	logic           pix_acc;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [EW-1:0]  col_ext;
	logic [HB-1:0]  row_ext;
	logic           col_wrap;
	logic           row_wrap;
	logic [CW-1:0]  rd_addr;
	flags_t         flags_in;

	assign adv       = !res_valid || !res_stall;
	assign pix_stall = !adv;
	assign pix_acc   = pix_valid && adv;

	assign col_ext  = EW'(col_q);
	assign row_ext  = HB'(row_q);
	assign col_wrap = (col_ext + EW'(1)) >= w_eff;
	assign row_wrap = (row_ext + HB'(1)) >= h_eff;
	assign rd_addr  = (col_ext < EW'(MAX_WIDTH)) ? col_q : CW'(MAX_WIDTH - 1);

	assign flags_in.emit = (row_q != '0) && (col_q != '0);
	assign flags_in.full = (row_q >= RW'(2)) && (col_q >= CW'(2));
	assign flags_in.last = (row_ext == h_eff - HB'(1)) && (col_ext == w_eff - EW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: line store data arrives; window shift and write-back.
	logic             valid_s1;
	flags_t           flags_s1;
	logic [PW-1:0]    pix_s1;
	logic [CW-1:0]    addr_s1;
	logic [2*PW-1:0]  ram_rdata;
	logic [PW-1:0]    top;
	logic [PW-1:0]    mid;
	logic             ram_we;
	logic [PW-1:0]    win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			flags_s1 <= '0;
		end else if (adv) begin
			valid_s1 <= pix_valid;
			flags_s1 <= pix_valid ? flags_in : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1  <= pixel_in;
			addr_s1 <= rd_addr;
		end
	end

	smte_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata ({mid, pix_s1}),
		.re    (pix_acc),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign top    = ram_rdata[2*PW-1:PW];
	assign mid    = ram_rdata[PW-1:0];
	assign ram_we = valid_s1 && adv;

	always_ff @(posedge clk) begin
		if (ram_we) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pix_s1;
		end
	end

	logic signed [PW+2:0] gx;
	logic signed [PW+2:0] gy;
	logic        [PW+1:0] sum_left;
	logic        [PW+1:0] sum_right;
	logic        [PW+1:0] sum_up;
	logic        [PW+1:0] sum_down;

	assign sum_left  = (PW+2)'(win_q[0]) + {1'b0, win_q[1], 1'b0} + (PW+2)'(win_q[2]);
	assign sum_right = (PW+2)'(top) + {1'b0, mid, 1'b0} + (PW+2)'(pix_s1);
	assign sum_up    = (PW+2)'(win_q[0]) + {1'b0, win_q[3], 1'b0} + (PW+2)'(top);
	assign sum_down  = (PW+2)'(win_q[2]) + {1'b0, win_q[5], 1'b0} + (PW+2)'(pix_s1);
	assign gx = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
	assign gy = $signed({1'b0, sum_up}) - $signed({1'b0, sum_down});

	// Stage 2: gradients registered; squares formed.
	flags_t               flags_s2;
	logic signed [PW+2:0] gx_s2;
	logic signed [PW+2:0] gy_s2;
	logic signed [2*PW+5:0] sqx;
	logic signed [2*PW+5:0] sqy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s2 <= '0;
		end else if (adv) begin
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2 <= gx;
			gy_s2 <= gy;
		end
	end

	assign sqx = gx_s2 * gx_s2;
	assign sqy = gy_s2 * gy_s2;

	// Stage 3: squares registered; magnitude compared.
	flags_t             flags_s3;
	logic [2*PW+3:0]    sqx_s3;
	logic [2*PW+3:0]    sqy_s3;
	logic [2*PW+4:0]    mag;
	logic               is_edge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s3 <= '0;
		end else if (adv) begin
			flags_s3 <= flags_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s3 <= sqx[2*PW+3:0];
			sqy_s3 <= sqy[2*PW+3:0];
		end
	end

	assign mag     = (2*PW+5)'(sqx_s3) + (2*PW+5)'(sqy_s3);
	assign is_edge = flags_s3.full && (mag > (2*PW+5)'(thr_sq_q));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid     <= 1'b0;
			last_of_frame <= 1'b0;
		end else if (adv) begin
			res_valid     <= flags_s3.emit;
			last_of_frame <= flags_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_out <= is_edge ? smte_pkg::EDGE_VALUE : smte_pkg::FLAT_VALUE;
		end
	end

`ifndef SYNTHESIS
	a_no_ram_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && pix_acc && (addr_s1 == rd_addr)))
		else $error("line store read and write hit the same column in one cycle");

	a_last_wraps_position: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && flags_in.last |=> (col_q == '0) && (row_q == '0))
		else $error("position did not return to frame start after the last pixel");

	a_result_needs_position: assert property (@(posedge clk) disable iff (!arst_n)
		flags_s1.full |-> flags_s1.emit)
		else $error("interior result flagged without a result transaction");
`endif

endmodule
